>>> hdl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Types, widths and the saturation helper shared by the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int EW      = 32;   // element width, Q16.16
	localparam int CW      = 65;   // exact cofactor width, signed
	localparam int DW      = 100;  // determinant / remainder width
	localparam int QW      = 32;   // quotient bits per lane
	localparam int NCOF    = 9;
	localparam int LATENCY = 40;   // start to done, in cycles

	typedef struct packed {
		logic signed [EW-1:0] in_r1c1;
		logic signed [EW-1:0] in_r1c2;
		logic signed [EW-1:0] in_r1c3;
		logic signed [EW-1:0] in_r2c1;
		logic signed [EW-1:0] in_r2c2;
		logic signed [EW-1:0] in_r2c3;
		logic signed [EW-1:0] in_r3c1;
		logic signed [EW-1:0] in_r3c2;
		logic signed [EW-1:0] in_r3c3;
	} matrix_t;

	typedef struct packed {
		logic signed [EW-1:0] out_r1c1;
		logic signed [EW-1:0] out_r1c2;
		logic signed [EW-1:0] out_r1c3;
		logic signed [EW-1:0] out_r2c1;
		logic signed [EW-1:0] out_r2c2;
		logic signed [EW-1:0] out_r2c3;
		logic signed [EW-1:0] out_r3c1;
		logic signed [EW-1:0] out_r3c2;
		logic signed [EW-1:0] out_r3c3;
		logic signed [EW-1:0] det_value;
		logic                 singular;
		logic                 overflowed;
	} result_t;

	typedef logic signed [CW-1:0] cof_t;

	// one divider lane
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QW-1:0] quo;
		logic          big;  // quotient known to be >= 2^32
		logic          neg;
	} lane_t;

	// per-item side data carried along the divider
	typedef struct packed {
		logic          zero;
		logic [QW-1:0] det_val;
		logic          det_ovf;
	} side_t;

	typedef struct packed {
		logic          ovf;
		logic [QW-1:0] val;
	} sat_t;

	// sign + magnitude to saturated two's complement
	function automatic sat_t sat32(input logic neg, input logic big, input logic [QW-1:0] mag);
		sat_t          r;
		logic [QW-1:0] lim;
		lim   = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		r.ovf = big || (mag > lim);
		if (r.ovf) begin
			r.val = lim;
		end else begin
			r.val = neg ? (~mag + 32'd1) : mag;
		end
		return r;
	endfunction

endpackage

>>> hdl/m3i_cofactor.sv
// ----------------------------------------------------------------------------
// m3i_cofactor
// Stages 1-2: the 18 element products, then the nine exact adjugate entries.
// ----------------------------------------------------------------------------
module m3i_cofactor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid,
	input  m3i_pkg::matrix_t               matrix,
	output logic                           valid_s2,
	output m3i_pkg::cof_t                  cof_s2 [m3i_pkg::NCOF],
	output logic signed [m3i_pkg::EW-1:0]  row1_s2 [3]
);

	logic signed [m3i_pkg::EW-1:0]   fa [m3i_pkg::NCOF];
	logic signed [m3i_pkg::EW-1:0]   fb [m3i_pkg::NCOF];
	logic signed [m3i_pkg::EW-1:0]   fc [m3i_pkg::NCOF];
	logic signed [m3i_pkg::EW-1:0]   fd [m3i_pkg::NCOF];
	logic signed [2*m3i_pkg::EW-1:0] pab_s1 [m3i_pkg::NCOF];
	logic signed [2*m3i_pkg::EW-1:0] pcd_s1 [m3i_pkg::NCOF];
	logic signed [m3i_pkg::EW-1:0]   row1_s1 [3];
	logic                            valid_s1;

	// adjugate entry i = fa*fb - fc*fd
	always_comb begin
		fa[0] = matrix.in_r2c2; fb[0] = matrix.in_r3c3; fc[0] = matrix.in_r2c3; fd[0] = matrix.in_r3c2;
		fa[1] = matrix.in_r1c3; fb[1] = matrix.in_r3c2; fc[1] = matrix.in_r1c2; fd[1] = matrix.in_r3c3;
		fa[2] = matrix.in_r1c2; fb[2] = matrix.in_r2c3; fc[2] = matrix.in_r1c3; fd[2] = matrix.in_r2c2;
		fa[3] = matrix.in_r2c3; fb[3] = matrix.in_r3c1; fc[3] = matrix.in_r2c1; fd[3] = matrix.in_r3c3;
		fa[4] = matrix.in_r1c1; fb[4] = matrix.in_r3c3; fc[4] = matrix.in_r1c3; fd[4] = matrix.in_r3c1;
		fa[5] = matrix.in_r1c3; fb[5] = matrix.in_r2c1; fc[5] = matrix.in_r1c1; fd[5] = matrix.in_r2c3;
		fa[6] = matrix.in_r2c1; fb[6] = matrix.in_r3c2; fc[6] = matrix.in_r2c2; fd[6] = matrix.in_r3c1;
		fa[7] = matrix.in_r1c2; fb[7] = matrix.in_r3c1; fc[7] = matrix.in_r1c1; fd[7] = matrix.in_r3c2;
		fa[8] = matrix.in_r1c1; fb[8] = matrix.in_r2c2; fc[8] = matrix.in_r1c2; fd[8] = matrix.in_r2c1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < m3i_pkg::NCOF; i++) begin
			pab_s1[i] <= fa[i] * fb[i];
			pcd_s1[i] <= fc[i] * fd[i];
			cof_s2[i] <= m3i_pkg::CW'(pab_s1[i]) - m3i_pkg::CW'(pcd_s1[i]);
		end
		row1_s1[0] <= matrix.in_r1c1;
		row1_s1[1] <= matrix.in_r1c2;
		row1_s1[2] <= matrix.in_r1c3;
		row1_s2    <= row1_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

endmodule

>>> hdl/m3i_det.sv
// ----------------------------------------------------------------------------
// m3i_det
// Stages 3-6: determinant by expansion along row 1, then magnitudes and signs.
// Each 65x32 product is split into two 33x32 partial products.
// ----------------------------------------------------------------------------
module m3i_det (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	input  m3i_pkg::cof_t                 cof [m3i_pkg::NCOF],
	input  logic signed [m3i_pkg::EW-1:0] row1 [3],
	output logic                          valid_s6,
	output logic [m3i_pkg::DW-1:0]        dmag_s6,
	output logic                          dneg_s6,
	output logic                          zero_s6,
	output logic [m3i_pkg::CW-1:0]        cmag_s6 [m3i_pkg::NCOF],
	output logic                          lneg_s6 [m3i_pkg::NCOF]
);

	logic signed [m3i_pkg::CW-1:0] lo_s3 [3];
	logic signed [m3i_pkg::CW-1:0] hi_s3 [3];
	logic signed [m3i_pkg::DW-1:0] term_s4 [3];
	logic signed [m3i_pkg::DW-1:0] det_s5;
	m3i_pkg::cof_t                 cof_s3 [m3i_pkg::NCOF];
	m3i_pkg::cof_t                 cof_s4 [m3i_pkg::NCOF];
	m3i_pkg::cof_t                 cof_s5 [m3i_pkg::NCOF];
	logic                          valid_s3, valid_s4, valid_s5;

	always_ff @(posedge clk) begin
		// row-1 term k uses adjugate entry 3k
		for (int k = 0; k < 3; k++) begin
			lo_s3[k]   <= $signed({1'b0, cof[3*k][31:0]}) * row1[k];
			hi_s3[k]   <= $signed(cof[3*k][m3i_pkg::CW-1:32]) * row1[k];
			term_s4[k] <= (m3i_pkg::DW'(hi_s3[k]) <<< 32) + m3i_pkg::DW'(lo_s3[k]);
		end
		det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];

		dneg_s6 <= det_s5[m3i_pkg::DW-1];
		zero_s6 <= (det_s5 == '0);
		dmag_s6 <= det_s5[m3i_pkg::DW-1] ? $unsigned(-det_s5) : $unsigned(det_s5);

		for (int i = 0; i < m3i_pkg::NCOF; i++) begin
			cof_s3[i]  <= cof[i];
			cof_s4[i]  <= cof_s3[i];
			cof_s5[i]  <= cof_s4[i];
			cmag_s6[i] <= cof_s5[i][m3i_pkg::CW-1] ? $unsigned(-cof_s5[i]) : $unsigned(cof_s5[i]);
			lneg_s6[i] <= cof_s5[i][m3i_pkg::CW-1] ^ det_s5[m3i_pkg::DW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s3 <= valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

endmodule

>>> hdl/m3i_divider.sv
// ----------------------------------------------------------------------------
// m3i_divider
// Stage 7 sets up nine lanes (overflow check, det saturation); stages 8-39
// each retire one restoring quotient bit of |adj| * 2^32 / |det| per lane.
// ----------------------------------------------------------------------------
module m3i_divider (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	input  logic [m3i_pkg::DW-1:0] dmag,
	input  logic                   dneg,
	input  logic                   zero,
	input  logic [m3i_pkg::CW-1:0] cmag [m3i_pkg::NCOF],
	input  logic                   lneg [m3i_pkg::NCOF],
	output logic                   valid_out,
	output m3i_pkg::lane_t         lane_out [m3i_pkg::NCOF],
	output m3i_pkg::side_t         side_out
);

	localparam int NS = m3i_pkg::QW + 1;

	// index 0 is the setup register, index k+1 holds k+1 quotient bits
	m3i_pkg::lane_t         lane_s [NS][m3i_pkg::NCOF];
	logic [m3i_pkg::DW-1:0] dmag_s [NS];
	m3i_pkg::side_t         side_s [NS];
	logic                   vld_s  [NS];

	logic [m3i_pkg::DW-1:0] shv [m3i_pkg::QW][m3i_pkg::NCOF];
	logic                   ge  [m3i_pkg::QW][m3i_pkg::NCOF];
	m3i_pkg::sat_t          dsat;

	always_comb begin
		dsat = m3i_pkg::sat32(dneg, |dmag[m3i_pkg::DW-1:64], dmag[63:32]);
		for (int k = 0; k < m3i_pkg::QW; k++) begin
			for (int i = 0; i < m3i_pkg::NCOF; i++) begin
				shv[k][i] = {lane_s[k][i].rem[m3i_pkg::DW-2:0], 1'b0};
				ge[k][i]  = (shv[k][i] >= dmag_s[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < m3i_pkg::NCOF; i++) begin
			// quotient fits 32 bits only when |adj| < |det|
			lane_s[0][i].rem <= m3i_pkg::DW'(cmag[i]);
			lane_s[0][i].quo <= '0;
			lane_s[0][i].big <= (m3i_pkg::DW'(cmag[i]) >= dmag);
			lane_s[0][i].neg <= lneg[i];
		end
		dmag_s[0]         <= dmag;
		side_s[0].zero    <= zero;
		side_s[0].det_val <= dsat.val;
		side_s[0].det_ovf <= dsat.ovf;

		for (int k = 0; k < m3i_pkg::QW; k++) begin
			for (int i = 0; i < m3i_pkg::NCOF; i++) begin
				lane_s[k+1][i].rem <= ge[k][i] ? (shv[k][i] - dmag_s[k]) : shv[k][i];
				lane_s[k+1][i].quo <= {lane_s[k][i].quo[m3i_pkg::QW-2:0], ge[k][i]};
				lane_s[k+1][i].big <= lane_s[k][i].big;
				lane_s[k+1][i].neg <= lane_s[k][i].neg;
			end
			dmag_s[k+1] <= dmag_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= valid;
			for (int k = 0; k < m3i_pkg::QW; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign valid_out = vld_s[NS-1];
	assign lane_out  = lane_s[NS-1];
	assign side_out  = side_s[NS-1];

endmodule

>>> hdl/m3i_output.sv
// ----------------------------------------------------------------------------
// m3i_output
// Stage 40: sign, saturation, singular handling and the result register.
// ----------------------------------------------------------------------------
module m3i_output (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	input  m3i_pkg::lane_t   lane [m3i_pkg::NCOF],
	input  m3i_pkg::side_t   side,
	output logic             done,
	output m3i_pkg::result_t result
);

	m3i_pkg::sat_t    ls [m3i_pkg::NCOF];
	m3i_pkg::result_t res;
	logic             any_ovf;
	logic             done_s40;

	always_comb begin
		any_ovf = side.det_ovf;
		for (int i = 0; i < m3i_pkg::NCOF; i++) begin
			ls[i]   = m3i_pkg::sat32(lane[i].neg, lane[i].big, lane[i].quo);
			any_ovf = any_ovf | ls[i].ovf;
		end
		res.out_r1c1   = ls[0].val;
		res.out_r1c2   = ls[1].val;
		res.out_r1c3   = ls[2].val;
		res.out_r2c1   = ls[3].val;
		res.out_r2c2   = ls[4].val;
		res.out_r2c3   = ls[5].val;
		res.out_r3c1   = ls[6].val;
		res.out_r3c2   = ls[7].val;
		res.out_r3c3   = ls[8].val;
		res.det_value  = side.det_val;
		res.singular   = 1'b0;
		res.overflowed = any_ovf;
		if (side.zero) begin
			res          = '0;
			res.singular = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		result <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s40 <= 1'b0;
		end else begin
			done_s40 <= valid;
		end
	end

	assign done = done_s40;

endmodule

>>> hdl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 Q16.16 matrix inverse by adjugate over determinant, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  request  | start / busy       | matrix (nine Q16.16 elements)
//  result   | done (1-cycle)     | result (inverse, det, flags)
//
// One request per cycle; results leave the output register in the order of their starts.
// Depth is set by the nine 32-step restoring divider lanes (one bit a stage).
// busy is always low; results cannot be held off and are never dropped.
// Reset clears only the valid bits; data registers run free.
module matrix3x3_inverse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  m3i_pkg::matrix_t matrix,
	output logic             done,
	output m3i_pkg::result_t result
);

	logic                          valid_s2;
	m3i_pkg::cof_t                 cof_s2 [m3i_pkg::NCOF];
	logic signed [m3i_pkg::EW-1:0] row1_s2 [3];

	logic                   valid_s6;
	logic [m3i_pkg::DW-1:0] dmag_s6;
	logic                   dneg_s6;
	logic                   zero_s6;
	logic [m3i_pkg::CW-1:0] cmag_s6 [m3i_pkg::NCOF];
	logic                   lneg_s6 [m3i_pkg::NCOF];

	logic           valid_s39;
	m3i_pkg::lane_t lane_s39 [m3i_pkg::NCOF];
	m3i_pkg::side_t side_s39;

	assign busy = 1'b0;

	m3i_cofactor u_cof (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (start & ~busy),
		.matrix   (matrix),
		.valid_s2 (valid_s2),
		.cof_s2   (cof_s2),
		.row1_s2  (row1_s2)
	);

	m3i_det u_det (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s2),
		.cof      (cof_s2),
		.row1     (row1_s2),
		.valid_s6 (valid_s6),
		.dmag_s6  (dmag_s6),
		.dneg_s6  (dneg_s6),
		.zero_s6  (zero_s6),
		.cmag_s6  (cmag_s6),
		.lneg_s6  (lneg_s6)
	);

	m3i_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s6),
		.dmag      (dmag_s6),
		.dneg      (dneg_s6),
		.zero      (zero_s6),
		.cmag      (cmag_s6),
		.lneg      (lneg_s6),
		.valid_out (valid_s39),
		.lane_out  (lane_s39),
		.side_out  (side_s39)
	);

	m3i_output u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s39),
		.lane   (lane_s39),
		.side   (side_s39),
		.done   (done),
		.result (result)
	);

endmodule

>>> hdl/m3i_checker.sv
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks for the 3x3 inverse: fixed latency and result flags.
// ----------------------------------------------------------------------------
module m3i_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input m3i_pkg::result_t result
);

	// every accepted request comes back after the fixed latency
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(m3i_pkg::LATENCY) done)
		else $error("request did not produce a result on time");

	// no result without a request at the matching cycle
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, m3i_pkg::LATENCY))
		else $error("result without a matching request");

	// singular results have zero det and diagonal and are never flagged as saturated
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.singular) |->
			(result.det_value == 0) && !result.overflowed &&
			(result.out_r1c1 == 0) && (result.out_r2c2 == 0) && (result.out_r3c3 == 0))
		else $error("singular result carries nonzero data");

	// fully pipelined: a request is taken every cycle
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a pipeline that never stalls");

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
